/* rtl/button_debounce_longpress_repeat_assert.svh */
// Assertion macros shared by the button debounce RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in the including module.
`ifndef BUTTON_DEBOUNCE_LONGPRESS_REPEAT_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONGPRESS_REPEAT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BDLR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDLR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bdlr_pkg.sv */
// Package for the button debouncer with long press and auto-repeat.
// Holds widths, the configuration struct, register indexes and event codes; no dependencies.
package bdlr_pkg;

    // Time arithmetic width; all time differences wrap at this width.
    localparam int TIME_BITS   = 32;
    localparam int NOW_W       = 32;
    localparam int CFG_W       = 16;
    localparam int NUM_BUTTONS = 3;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;
    localparam int CODE_W      = 4;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CFG_W-1:0]     cfg_val_t;
    typedef logic [1:0]           ev_kind_t;
    typedef logic [CODE_W-1:0]    code_t;

    typedef struct packed {
        cfg_val_t debounce_time;
        cfg_val_t long_press_time;
        cfg_val_t repeat_slow_interval;
        cfg_val_t repeat_fast_interval;
        cfg_val_t fast_switch_time;
    } cfg_t;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_SLOW = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_FAST = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FAST_SWITCH = 3'd4;

    // Reset values of the configuration registers.
    localparam cfg_val_t RST_DEBOUNCE    = 16'd50;
    localparam cfg_val_t RST_LONG_PRESS  = 16'd800;
    localparam cfg_val_t RST_REPEAT_SLOW = 16'd400;
    localparam cfg_val_t RST_REPEAT_FAST = 16'd100;
    localparam cfg_val_t RST_FAST_SWITCH = 16'd2000;

    // Per-button event kinds.
    localparam ev_kind_t EV_NONE   = 2'd0;
    localparam ev_kind_t EV_SHORT  = 2'd1;
    localparam ev_kind_t EV_LONG   = 2'd2;
    localparam ev_kind_t EV_REPEAT = 2'd3;

    // Result codes: a button's base plus its event kind.
    localparam code_t EVC_NONE        = 4'd0;
    localparam code_t EVC_UP_BASE     = 4'd0;
    localparam code_t EVC_DOWN_BASE   = 4'd3;
    localparam code_t EVC_SELECT_BASE = 4'd6;
    localparam code_t EVC_SELECT_LONG = 4'd8;

    // Button positions in the raw level vector and in priority order.
    localparam int BTN_UP     = 0;
    localparam int BTN_DOWN   = 1;
    localparam int BTN_SELECT = 2;

    // Widens a configuration value into the time domain.
    function automatic time_t cfg_to_time(input cfg_val_t v);
        return time_t'(v);
    endfunction

endpackage

/* rtl/bdlr_cfg_regs.sv */
// APB-style configuration registers of the button debouncer.
// Depends on bdlr_pkg for the register indexes, reset values and cfg_t.
module bdlr_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bdlr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bdlr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bdlr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output bdlr_pkg::cfg_t                    cfg
);
    import bdlr_pkg::*;

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;
    cfg_val_t              wr_val;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign wr_val  = pwdata[CFG_W-1:0];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Write decode; an index past the last register is ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_DEBOUNCE:    cfg_next.debounce_time        = wr_val;
                REG_LONG_PRESS:  cfg_next.long_press_time      = wr_val;
                REG_REPEAT_SLOW: cfg_next.repeat_slow_interval = wr_val;
                REG_REPEAT_FAST: cfg_next.repeat_fast_interval = wr_val;
                REG_FAST_SWITCH: cfg_next.fast_switch_time     = wr_val;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time        <= RST_DEBOUNCE;
            cfg_reg.long_press_time      <= RST_LONG_PRESS;
            cfg_reg.repeat_slow_interval <= RST_REPEAT_SLOW;
            cfg_reg.repeat_fast_interval <= RST_REPEAT_FAST;
            cfg_reg.fast_switch_time     <= RST_FAST_SWITCH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux.
    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE:    prdata = APB_DATA_W'(cfg_reg.debounce_time);
            REG_LONG_PRESS:  prdata = APB_DATA_W'(cfg_reg.long_press_time);
            REG_REPEAT_SLOW: prdata = APB_DATA_W'(cfg_reg.repeat_slow_interval);
            REG_REPEAT_FAST: prdata = APB_DATA_W'(cfg_reg.repeat_fast_interval);
            REG_FAST_SWITCH: prdata = APB_DATA_W'(cfg_reg.fast_switch_time);
            default:         prdata = '0;
        endcase
    end

endmodule

/* rtl/bdlr_button.sv */
// One button's debounce, short/long press and auto-repeat tracker.
// Depends on bdlr_pkg; state advances only on a cycle where commit is high.
module bdlr_button (
    input  logic               aclk,
    input  logic               aresetn,
    input  bdlr_pkg::cfg_t     cfg,
    input  bdlr_pkg::time_t    now,
    input  logic               raw,
    input  logic               commit,
    output bdlr_pkg::ev_kind_t ev_kind
);
    import bdlr_pkg::*;

    logic  last_raw_reg,    last_raw_next;
    logic  stable_reg,      stable_next;
    logic  long_done_reg,   long_done_next;
    time_t change_time_reg, change_time_next;
    time_t press_time_reg,  press_time_next;
    time_t repeat_time_reg, repeat_time_next;

    time_t deb_diff;
    time_t held;
    time_t rep_diff;
    time_t interval;
    logic  deb_ok;

    // Debounce window: restarts whenever the raw level changes.
    always_comb begin
        last_raw_next    = raw;
        change_time_next = (raw != last_raw_reg) ? now : change_time_reg;
        deb_diff         = now - change_time_next;
        deb_ok           = deb_diff >= cfg_to_time(cfg.debounce_time);
    end

    // Stable level, press timing, long event and repeat timing.
    always_comb begin
        stable_next      = stable_reg;
        long_done_next   = long_done_reg;
        press_time_next  = press_time_reg;
        repeat_time_next = repeat_time_reg;
        held             = '0;
        rep_diff         = '0;
        interval         = '0;
        ev_kind          = EV_NONE;
        if (deb_ok) begin
            if (raw != stable_reg) begin
                stable_next = raw;
                if (raw) begin
                    press_time_next  = now;
                    long_done_next   = 1'b0;
                    repeat_time_next = now;
                end else begin
                    // Release: a short event only if no long event was given.
                    ev_kind = long_done_reg ? EV_NONE : EV_SHORT;
                end
            end
            if (stable_next) begin
                held     = now - press_time_next;
                rep_diff = now - repeat_time_next;
                interval = (held < cfg_to_time(cfg.fast_switch_time))
                         ? cfg_to_time(cfg.repeat_slow_interval)
                         : cfg_to_time(cfg.repeat_fast_interval);
                if (!long_done_next) begin
                    if (held >= cfg_to_time(cfg.long_press_time)) begin
                        long_done_next   = 1'b1;
                        repeat_time_next = now;
                        ev_kind          = EV_LONG;
                    end
                end else if (rep_diff >= interval) begin
                    repeat_time_next = now;
                    ev_kind          = EV_REPEAT;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg    <= 1'b0;
            stable_reg      <= 1'b0;
            long_done_reg   <= 1'b0;
            change_time_reg <= '0;
            press_time_reg  <= '0;
            repeat_time_reg <= '0;
        end else if (commit) begin
            last_raw_reg    <= last_raw_next;
            stable_reg      <= stable_next;
            long_done_reg   <= long_done_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
            repeat_time_reg <= repeat_time_next;
        end
    end

endmodule

/* rtl/button_debounce_longpress_repeat.sv */
// Top level of the three-button debouncer with long press and auto-repeat.
// Depends on bdlr_pkg, bdlr_cfg_regs, bdlr_button and the assertion macro header.
//
//   channel   ports                                  direction  item
//   input     s_valid s_ready s_now_ms s_raw_buttons  in         one poll
//   result    m_valid m_ready m_event_code            out        one event code per poll
//   config    psel penable pwrite paddr pwdata ...    in/out     APB register access
//
// A poll is registered on acceptance and evaluated into the result register once that
// register is free or being taken; one poll per cycle is sustained while m_ready stays high.
// The button state update and the up/down/select priority resolve in that single evaluation.
// A stalled result register holds the input register, and s_ready then drops.
// Active-low synchronous reset clears the pipeline and button state, sets config defaults.
`include "button_debounce_longpress_repeat_assert.svh"

module button_debounce_longpress_repeat (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bdlr_pkg::NOW_W-1:0]        s_now_ms,
    input  logic [bdlr_pkg::NUM_BUTTONS-1:0]  s_raw_buttons,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bdlr_pkg::CODE_W-1:0]       m_event_code,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bdlr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bdlr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bdlr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import bdlr_pkg::*;

    cfg_t                   cfg;
    logic                   in_valid_reg, in_valid_next;
    time_t                  in_now_reg;
    logic [NUM_BUTTONS-1:0] in_raw_reg;
    logic                   m_valid_reg,  m_valid_next;
    code_t                  m_code_reg,   m_code_next;
    logic                   advance;
    logic                   in_take;
    logic [NUM_BUTTONS-1:0] commit;
    ev_kind_t               ev_up, ev_down, ev_sel;

    bdlr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline handshake: the input register moves on when the result register is free.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        m_valid_next  = advance ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // A later button only updates when every earlier one gave no event.
    assign commit[BTN_UP]     = advance;
    assign commit[BTN_DOWN]   = advance && (ev_up == EV_NONE);
    assign commit[BTN_SELECT] = advance && (ev_up == EV_NONE) && (ev_down == EV_NONE);

    bdlr_button u_btn_up (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .now     (in_now_reg),
        .raw     (in_raw_reg[BTN_UP]),
        .commit  (commit[BTN_UP]),
        .ev_kind (ev_up)
    );

    bdlr_button u_btn_down (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .now     (in_now_reg),
        .raw     (in_raw_reg[BTN_DOWN]),
        .commit  (commit[BTN_DOWN]),
        .ev_kind (ev_down)
    );

    bdlr_button u_btn_sel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .now     (in_now_reg),
        .raw     (in_raw_reg[BTN_SELECT]),
        .commit  (commit[BTN_SELECT]),
        .ev_kind (ev_sel)
    );

    // Priority encode; a repeat from select reports nothing.
    always_comb begin
        priority if (ev_up != EV_NONE) begin
            m_code_next = EVC_UP_BASE + code_t'(ev_up);
        end else if (ev_down != EV_NONE) begin
            m_code_next = EVC_DOWN_BASE + code_t'(ev_down);
        end else if (ev_sel == EV_SHORT || ev_sel == EV_LONG) begin
            m_code_next = EVC_SELECT_BASE + code_t'(ev_sel);
        end else begin
            m_code_next = EVC_NONE;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_now_reg <= s_now_ms[TIME_BITS-1:0];
            in_raw_reg <= s_raw_buttons;
        end
        if (advance) begin
            m_code_reg <= m_code_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_code = m_code_reg;

    `BDLR_ASSERT_IMP(a_code_range, m_valid, m_event_code <= EVC_SELECT_LONG, "event code out of range")
    `BDLR_ASSERT_NXT(a_take_fills, in_take, in_valid_reg, "accepted item not held in input register")
    `BDLR_ASSERT_NXT(a_advance_fills, advance, m_valid_reg, "evaluated item lost before result")
    `BDLR_ASSERT_IMP(a_stall_blocks, in_valid_reg && m_valid_reg && !m_ready, !s_ready && !advance, "input taken while result stalled")

endmodule

/* sim/tb_button_debounce_longpress_repeat.sv */
// Self-checking testbench for the three-button debouncer with long press and auto-repeat.
// Polls go in through a valid/ready driver and codes are checked against an in-bench predictor.
// Depends on bdlr_pkg and the button_debounce_longpress_repeat top level.
module tb_button_debounce_longpress_repeat;
    timeunit 1ns;
    timeprecision 1ps;

    import bdlr_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SHOW_LIMIT   = 10;
    // Addresses past the last register; writes there must change nothing.
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        time_t      now_ms;
        logic [2:0] raw;
    } poll_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic [NOW_W-1:0]        s_now_ms      = '0;
    logic [NUM_BUTTONS-1:0]  s_raw_buttons = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic [CODE_W-1:0]       m_event_code;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr         = '0;
    logic [APB_DATA_W-1:0]   pwdata        = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    button_debounce_longpress_repeat dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_now_ms      (s_now_ms),
        .s_raw_buttons (s_raw_buttons),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_code  (m_event_code),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Polls waiting to be offered, and event codes predicted for accepted polls.
    poll_t poll_q[$];
    code_t predicted_codes[$];
    poll_t next_poll;
    code_t want_code;
    time_t poll_ms;

    int unsigned n_pushed   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results  = 0;
    int unsigned n_fail     = 0;
    int unsigned n_settings = 1;
    int unsigned cycles     = 0;
    int unsigned stall_left = 0;
    bit          stall_done = 1'b0;
    int unsigned kind_hits [4];

    // Predictor copy of the registers and of the per-button state.
    cfg_t  cfg_now;
    logic  lvl_seen   [NUM_BUTTONS];
    logic  is_pressed [NUM_BUTTONS];
    time_t edge_ms    [NUM_BUTTONS];
    time_t press_ms   [NUM_BUTTONS];
    logic  long_fired [NUM_BUTTONS];
    time_t repeat_ms  [NUM_BUTTONS];

    // Debounces one button and returns the event kind it yields on this poll.
    function automatic ev_kind_t step_button(input int k, input logic lvl, input time_t now);
        time_t since_edge, held, since_rep, iv;
        if (lvl != lvl_seen[k]) begin
            edge_ms[k]  = now;
            lvl_seen[k] = lvl;
        end
        since_edge = now - edge_ms[k];
        if (since_edge < time_t'(cfg_now.debounce_time))
            return EV_NONE;
        if (lvl != is_pressed[k]) begin
            is_pressed[k] = lvl;
            if (lvl) begin
                press_ms[k]   = now;
                long_fired[k] = 1'b0;
                repeat_ms[k]  = now;
            end else begin
                // A release after the long event is silent.
                return long_fired[k] ? EV_NONE : EV_SHORT;
            end
        end
        if (is_pressed[k]) begin
            held = now - press_ms[k];
            if (!long_fired[k] && held >= time_t'(cfg_now.long_press_time)) begin
                long_fired[k] = 1'b1;
                repeat_ms[k]  = now;
                return EV_LONG;
            end
            if (long_fired[k]) begin
                iv = (held < time_t'(cfg_now.fast_switch_time)) ?
                     time_t'(cfg_now.repeat_slow_interval) :
                     time_t'(cfg_now.repeat_fast_interval);
                since_rep = now - repeat_ms[k];
                if (since_rep >= iv) begin
                    repeat_ms[k] = now;
                    return EV_REPEAT;
                end
            end
        end
        return EV_NONE;
    endfunction

    // Walks the buttons in priority order; the first event ends the poll.
    function automatic code_t predict_event(input time_t now, input logic [2:0] raw);
        ev_kind_t ev;
        ev_kind_t kind;
        code_t    code;
        kind = EV_NONE;
        code = EVC_NONE;
        ev = step_button(BTN_UP, raw[BTN_UP], now);
        if (ev != EV_NONE) begin
            kind = ev;
            code = EVC_UP_BASE + code_t'(ev);
        end else begin
            ev = step_button(BTN_DOWN, raw[BTN_DOWN], now);
            if (ev != EV_NONE) begin
                kind = ev;
                code = EVC_DOWN_BASE + code_t'(ev);
            end else begin
                // Select repeats move its state on but are not reported.
                ev = step_button(BTN_SELECT, raw[BTN_SELECT], now);
                if (ev == EV_SHORT || ev == EV_LONG) begin
                    kind = ev;
                    code = EVC_SELECT_BASE + code_t'(ev);
                end
            end
        end
        kind_hits[kind]++;
        return code;
    endfunction

    // Driver: offers queued polls, predicts each accepted item, idles at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_codes.push_back(predict_event(s_now_ms, s_raw_buttons));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (poll_q.size() != 0 &&
                    ((n_accepted >= 300 && n_accepted < 450) ||
                     $urandom_range(0, 99) >= 20)) begin
                    next_poll = poll_q.pop_front();
                    s_valid       <= 1'b1;
                    s_now_ms      <= next_poll.now_ms;
                    s_raw_buttons <= next_poll.raw;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result item against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_codes.size() == 0) begin
                    if (n_fail < SHOW_LIMIT)
                        $display("result %0d: code %0d arrived with no poll pending",
                                 n_results, m_event_code);
                    n_fail++;
                end else begin
                    want_code = predicted_codes.pop_front();
                    if (m_event_code !== want_code) begin
                        if (n_fail < SHOW_LIMIT)
                            $display("result %0d: event_code expected %0d, got %0d",
                                     n_results, want_code, m_event_code);
                        n_fail++;
                    end
                end
                n_results++;
            end
            // One long hold-off so the pipeline fills and the input stalls.
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!stall_done && n_results >= 60) begin
                stall_done = 1'b1;
                stall_left = 80;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (n_results >= 300 && n_results < 450) ||
                           $urandom_range(0, 99) >= 20;
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Run stopped after %0d cycles with %0d of %0d results in.",
                     cycles, n_results, n_pushed);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_poll(input time_t now, input logic [2:0] raw);
        poll_t p;
        p.now_ms = now;
        p.raw    = raw;
        poll_q.push_back(p);
        n_pushed++;
    endtask

    // Waits until every queued poll has produced its result, then lets the pipe settle.
    task automatic drain();
        while (n_results < n_pushed)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; junk in the upper half must be dropped.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input cfg_val_t value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEBOUNCE:    cfg_now.debounce_time        = value;
            REG_LONG_PRESS:  cfg_now.long_press_time      = value;
            REG_REPEAT_SLOW: cfg_now.repeat_slow_interval = value;
            REG_REPEAT_FAST: cfg_now.repeat_fast_interval = value;
            REG_FAST_SWITCH: cfg_now.fast_switch_time     = value;
            default: ;
        endcase
    endtask

    task automatic set_timing(input cfg_val_t deb, input cfg_val_t lng, input cfg_val_t slow,
                              input cfg_val_t fast, input cfg_val_t sw);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG_PRESS, lng);
        write_reg(REG_REPEAT_SLOW, slow);
        write_reg(REG_REPEAT_FAST, fast);
        write_reg(REG_FAST_SWITCH, sw);
        n_settings++;
    endtask

    // One press of the buttons in mask: optional contact bounce, a hold sized
    // from the current timing, then a release long enough to debounce.
    task automatic press_gesture(input logic [2:0] mask);
        int unsigned deb, lng, hold, n_hold, step, n_bounce, n_rel, i;
        logic [2:0]  rel;
        deb = cfg_now.debounce_time;
        lng = cfg_now.long_press_time;
        case ($urandom_range(0, 3))
            0: hold = $urandom_range(0, lng);
            1: hold = lng + $urandom_range(0, 3 * cfg_now.repeat_slow_interval + 10);
            default: hold = lng + cfg_now.fast_switch_time +
                            $urandom_range(0, 6 * cfg_now.repeat_fast_interval + 10);
        endcase
        hold     = hold + deb;
        n_hold   = $urandom_range(3, 14);
        step     = hold / n_hold + 1;
        n_bounce = $urandom_range(0, 1) ? $urandom_range(1, 3) : 0;
        for (i = 0; i < n_bounce; i++) begin
            poll_ms += $urandom_range(0, deb / 2);
            add_poll(poll_ms, (i % 2 == 0) ? mask : 3'b000);
        end
        for (i = 0; i < n_hold; i++) begin
            poll_ms += $urandom_range(step / 2 + 1, step + step / 2);
            add_poll(poll_ms, mask);
        end
        // Mostly a clean release; now and then another chord takes over.
        rel   = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'b000;
        n_rel = $urandom_range(3, 4);
        for (i = 0; i < n_rel; i++) begin
            poll_ms += $urandom_range(deb / 2 + 1, deb / 2 + deb / 4 + 6);
            add_poll(poll_ms, rel);
        end
    endtask

    // Random levels at random spacing, with the odd jump anywhere on the time line.
    task automatic noise_burst();
        int unsigned n, i;
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0)
                poll_ms = $urandom;
            else
                poll_ms += $urandom_range(0, cfg_now.debounce_time + 20);
            add_poll(poll_ms, 3'($urandom_range(0, 7)));
        end
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned start;
        start = n_pushed;
        while (n_pushed - start < target) begin
            case ($urandom_range(0, 9))
                0:       noise_burst();
                1:       press_gesture(3'($urandom_range(1, 7)));
                default: press_gesture(3'(1 << $urandom_range(0, 2)));
            endcase
        end
    endtask

    initial begin
        int p;
        cfg_now = '{debounce_time: RST_DEBOUNCE, long_press_time: RST_LONG_PRESS,
                    repeat_slow_interval: RST_REPEAT_SLOW,
                    repeat_fast_interval: RST_REPEAT_FAST,
                    fast_switch_time: RST_FAST_SWITCH};
        for (p = 0; p < NUM_BUTTONS; p++) begin
            lvl_seen[p]   = 1'b0;
            is_pressed[p] = 1'b0;
            edge_ms[p]    = '0;
            press_ms[p]   = '0;
            long_fired[p] = 1'b0;
            repeat_ms[p]  = '0;
        end
        for (p = 0; p < 4; p++)
            kind_hits[p] = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed polls at the reset timing: up short, down long with slow and
        // fast repeats, a lower button masked by an earlier event, select long
        // and its silent repeat, a hold across the time wrap, field extremes.
        add_poll(32'd0, 3'b000);
        add_poll(32'd10, 3'b001);
        add_poll(32'd70, 3'b001);
        add_poll(32'd120, 3'b000);
        add_poll(32'd180, 3'b000);
        add_poll(32'd200, 3'b010);
        add_poll(32'd260, 3'b010);
        add_poll(32'd1100, 3'b010);
        add_poll(32'd1500, 3'b010);
        add_poll(32'd2300, 3'b010);
        add_poll(32'd2400, 3'b110);
        add_poll(32'd2450, 3'b100);
        add_poll(32'd2510, 3'b100);
        add_poll(32'd3400, 3'b100);
        add_poll(32'd3800, 3'b100);
        add_poll(32'd3850, 3'b101);
        add_poll(32'd3920, 3'b001);
        add_poll(32'hFFFF_FFE0, 3'b001);
        add_poll(32'h0000_0010, 3'b001);
        add_poll(32'h0000_0050, 3'b001);
        add_poll(32'h0000_0060, 3'b111);
        add_poll(32'hFFFF_FFFF, 3'b111);
        add_poll(32'h0000_00A0, 3'b000);
        drain();

        // All intervals zero: every held poll after the long event repeats.
        set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h1234);
        poll_ms = $urandom;
        run_random(150);
        drain();

        // All intervals at their maximum, starting just short of the wrap.
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        poll_ms = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
        run_random(150);
        drain();

        // Typical timings, then one setting drawn from the full register range.
        for (p = 0; p < 4; p++) begin
            if (p == 3)
                set_timing(16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom));
            else
                set_timing(16'($urandom_range(0, 100)), 16'($urandom_range(0, 1500)),
                           16'($urandom_range(0, 500)), 16'($urandom_range(0, 200)),
                           16'($urandom_range(0, 3000)));
            poll_ms = $urandom;
            run_random(150);
            drain();
        end

        $display("Checked %0d polls over %0d timing settings, with bounce, chords and wrap.",
                 n_results, n_settings);
        $display("Reported events: %0d short, %0d long, %0d repeat, %0d quiet polls.",
                 kind_hits[EV_SHORT], kind_hits[EV_LONG], kind_hits[EV_REPEAT],
                 kind_hits[EV_NONE]);
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches in total.", n_fail);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
